/* design/bcsr_pkg.sv */
// ----------------------------------------------------------------------------
// bcsr_pkg
// Shared constants, request codes and IEEE single precision helpers for the
// 1x4 block sparse matrix-vector accumulator.
// ----------------------------------------------------------------------------
package bcsr_pkg;

    localparam int LANES     = 4;
    localparam int LANE_W    = $clog2(LANES);
    localparam int VEC_DEPTH = 4096;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int ROW_DEPTH = VEC_DEPTH / LANES;
    localparam int ROW_AW    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int MAX_ROWS  = 65536;
    localparam int ROW_W     = 16;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        REQ_VEC = 2'd0,
        REQ_BLK = 2'd1,
        REQ_FIN = 2'd2
    } req_t;

    typedef logic [31:0] fp_t;

    // Row finish handed from the accumulate stage to the reduction stages
    typedef struct packed {
        logic              vld;
        logic [ROW_W-1:0]  row;
        fp_t               c_prior;
        fp_t               r0;
        fp_t               r1;
    } fin_t;

    function automatic logic [5:0] lzc48(logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(logic [26:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    // Round to nearest even and pack. sig has its leading one at bit 26 for
    // e >= 1; bits 2..0 are guard, round and sticky.
    function automatic fp_t fp_round(logic s, logic signed [11:0] e, logic [26:0] sig);
        logic [26:0] sg;
        logic [11:0] sh;
        logic [26:0] mask;
        logic [24:0] m;
        logic        up;
        logic [8:0]  ex;
        fp_t         r;
        sg = sig;
        if (e <= 12'sd0) begin
            sh = 12'd1 - e;
            if (sh >= 12'd27) begin
                sg = {26'd0, |sig};
            end else begin
                mask = (27'd1 << sh) - 27'd1;
                sg   = (sig >> sh) | {26'd0, |(sig & mask)};
            end
            ex = 9'd0;
        end else begin
            ex = e[8:0];
        end
        up = sg[2] & (sg[1] | sg[0] | sg[3]);
        m  = {1'b0, sg[26:3]} + {24'd0, up};
        if (ex == 9'd0) begin
            r = {s, 7'd0, m[23], m[22:0]};
        end else if (m[24]) begin
            ex = ex + 9'd1;
            r  = {s, ex[7:0], m[23:1]};
        end else begin
            r = {s, ex[7:0], m[22:0]};
        end
        if (ex >= 9'd255) r = {s, 8'hFF, 23'd0};
        return r;
    endfunction

    function automatic fp_t fp_mul(fp_t a, fp_t b);
        logic              s;
        logic [7:0]        ea, eb;
        logic [22:0]       fa, fb;
        logic [23:0]       ma, mb;
        logic [47:0]       p, pn;
        logic [5:0]        lz;
        logic signed [11:0] e;
        logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        fp_t               r;
        s  = a[31] ^ b[31];
        ea = a[30:23]; fa = a[22:0];
        eb = b[30:23]; fb = b[22:0];
        a_nan  = (ea == 8'hFF) && (fa != 23'd0);
        b_nan  = (eb == 8'hFF) && (fb != 23'd0);
        a_inf  = (ea == 8'hFF) && (fa == 23'd0);
        b_inf  = (eb == 8'hFF) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        ma = {ea != 8'd0, fa};
        mb = {eb != 8'd0, fb};
        p  = ma * mb;
        lz = lzc48(p);
        pn = p << lz;
        e  = 12'(ea == 8'd0 ? 8'd1 : ea) + 12'(eb == 8'd0 ? 8'd1 : eb)
             - 12'sd126 - 12'(lz);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            r = QNAN;
        end else if (a_inf || b_inf) begin
            r = {s, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            r = {s, 31'd0};
        end else begin
            r = fp_round(s, e, {pn[47:22], |pn[21:0]});
        end
        return r;
    endfunction

    function automatic fp_t fp_add(fp_t a, fp_t b);
        fp_t               x, y, r;
        logic [7:0]        ex, ey, d;
        logic [26:0]       ax, by, bs, sig, mask;
        logic [27:0]       sm;
        logic [4:0]        lz;
        logic signed [11:0] e;
        logic              a_nan, b_nan, a_inf, b_inf;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (a[30:0] < b[30:0]) begin
            x = b; y = a;
        end else begin
            x = a; y = b;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        ax = {x[30:23] != 8'd0, x[22:0], 3'b000};
        by = {y[30:23] != 8'd0, y[22:0], 3'b000};
        if (d >= 8'd27) begin
            bs = {26'd0, |by};
        end else begin
            mask = (27'd1 << d) - 27'd1;
            bs   = (by >> d) | {26'd0, |(by & mask)};
        end
        if (x[31] == y[31]) sm = {1'b0, ax} + {1'b0, bs};
        else                sm = {1'b0, ax} - {1'b0, bs};
        lz = lzc27(sm[26:0]);
        if (sm[27]) begin
            sig = {sm[27:2], sm[1] | sm[0]};
            e   = 12'(ex) + 12'sd1;
        end else begin
            sig = sm[26:0] << lz;
            e   = 12'(ex) - 12'(lz);
        end
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            r = QNAN;
        end else if (a_inf) begin
            r = a;
        end else if (b_inf) begin
            r = b;
        end else if (sm == 28'd0) begin
            r = {x[31] & y[31], 31'd0};
        end else begin
            r = fp_round(x[31], e, sig);
        end
        return r;
    endfunction

endpackage

/* design/bcsr_ram.sv */
// ----------------------------------------------------------------------------
// bcsr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end

endmodule

/* design/bcsr_reduce.sv */
// ----------------------------------------------------------------------------
// bcsr_reduce
// Final reduction of a finished row: sum the two lane pairs, add the prior
// value, hold the result in the output register.
// ----------------------------------------------------------------------------
module bcsr_reduce import bcsr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  fin_t             fin,
    output logic             adv,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ROW_W-1:0] m_row_number,
    output logic [31:0]      m_row_result
);

    logic             p3_vld_reg, p4_vld_reg, out_vld_reg;
    logic [ROW_W-1:0] p3_row_reg, p4_row_reg, out_row_reg;
    fp_t              p3_c_reg, p3_r0_reg, p3_r1_reg;
    fp_t              p4_c_reg, p4_tot_reg, out_res_reg;
    fp_t              res_next;

    // Stall only when a result is ready to load and the output is still full
    assign adv = !(p4_vld_reg && out_vld_reg && !m_ready);

    always_comb begin
        res_next = fp_add(p4_c_reg, p4_tot_reg);
        if (res_next[30:23] == 8'hFF && res_next[22:0] != 23'd0) res_next = QNAN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            // keep an unaccepted result, load a new one when the stage advances
            out_vld_reg <= (out_vld_reg && !m_ready) || (adv && p4_vld_reg);
            if (adv) begin
                p3_vld_reg <= fin.vld;
                p4_vld_reg <= p3_vld_reg;
            end
        end
        if (adv) begin
            p3_row_reg <= fin.row;
            p3_c_reg   <= fin.c_prior;
            p3_r0_reg  <= fin.r0;
            p3_r1_reg  <= fin.r1;
            p4_row_reg <= p3_row_reg;
            p4_c_reg   <= p3_c_reg;
            p4_tot_reg <= fp_add(p3_r0_reg, p3_r1_reg);
            if (p4_vld_reg) begin
                out_row_reg <= p4_row_reg;
                out_res_reg <= res_next;
            end
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_row_number = out_row_reg;
    assign m_row_result = out_res_reg;

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> (p4_vld_reg && m_valid))
        else $error("reduce stalled without a pending result");

    a_load_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (p4_vld_reg && adv) |=> out_vld_reg)
        else $error("finished row lost at output register");

    a_no_nan_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_result[30:23] == 8'hFF && m_row_result[22:0] != 23'd0
        |-> m_row_result == QNAN)
        else $error("non-canonical NaN on output");

endmodule

/* design/block_csr_spmv_accumulator.sv */
// ----------------------------------------------------------------------------
// block_csr_spmv_accumulator
// 1x4 block sparse matrix times dense vector, IEEE single precision.
//
//   channel | direction | ports                                  | content
//   --------+-----------+----------------------------------------+------------------
//   s_      | in        | s_valid/s_ready, s_req_type .. s_c_prior | vector write,
//           |           |                                        | block, row finish
//   m_      | out       | m_valid/m_ready, m_row_number, m_row_result | finished row
//
// One transaction is taken every cycle unless the pipeline stalls. The dense
// vector lives in four lane RAMs (one word of each block column per lane), so
// a block reads all four elements together. A finish-row result passes the
// stage 1, stage 2, p3, p4 and output registers. The lane accumulators close
// their add combinationally, which lets blocks of the same row follow each
// other without gaps. Reset (synchronous, aresetn low) clears pipeline valids,
// lane sums and the row count; vector RAM contents stay undefined until written.
// The whole pipeline stalls only while a result waits in the full output register.
// ----------------------------------------------------------------------------
module block_csr_spmv_accumulator import bcsr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [11:0]      s_vec_index,
    input  logic [31:0]      s_vec_value,
    input  logic [9:0]       s_block_col,
    input  logic [31:0]      s_val0,
    input  logic [31:0]      s_val1,
    input  logic [31:0]      s_val2,
    input  logic [31:0]      s_val3,
    input  logic [31:0]      s_c_prior,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ROW_W-1:0] m_row_number,
    output logic [31:0]      m_row_result
);

    logic              adv;
    logic              accept;
    logic [VEC_AW-1:0] widx;
    logic [ROW_AW-1:0] rrow;
    fp_t               vec_rd [LANES];
    fp_t               s_vals [LANES];

    // stage 1: RAM read in flight
    logic              p1_vld_reg;
    req_t              p1_req_reg;
    fp_t               p1_val_reg [LANES];
    fp_t               p1_c_reg;

    // stage 2: rounded products, accumulate
    logic              p2_vld_reg;
    req_t              p2_req_reg;
    fp_t               p2_prod_reg [LANES];
    fp_t               p2_c_reg;

    fp_t               acc_reg [LANES];
    fp_t               acc_next [LANES];
    fp_t               add_out [LANES];
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              fin_now, blk_now;
    fin_t              fin;

    assign s_ready = adv;
    assign accept  = s_valid && adv;
    assign widx    = VEC_AW'(s_vec_index);
    assign rrow    = ROW_AW'(s_block_col);

    assign s_vals[0] = s_val0;
    assign s_vals[1] = s_val1;
    assign s_vals[2] = s_val2;
    assign s_vals[3] = s_val3;

    // One RAM per lane; element i sits in lane i mod 4 at row i / 4
    for (genvar g = 0; g < LANES; g++) begin : g_vec
        bcsr_ram #(.WIDTH(32), .DEPTH(ROW_DEPTH)) u_ram (
            .aclk  (aclk),
            .we    (accept && req_t'(s_req_type) == REQ_VEC
                    && widx[LANE_W-1:0] == LANE_W'(g)),
            .waddr (ROW_AW'(widx >> LANE_W)),
            .wdata (s_vec_value),
            .re    (adv),
            .raddr (rrow),
            .rdata (vec_rd[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= s_valid;
            p2_vld_reg <= p1_vld_reg;
        end
        if (adv) begin
            p1_req_reg <= req_t'(s_req_type);
            p1_c_reg   <= s_c_prior;
            p2_req_reg <= p1_req_reg;
            p2_c_reg   <= p1_c_reg;
            for (int i = 0; i < LANES; i++) begin
                p1_val_reg[i]  <= s_vals[i];
                p2_prod_reg[i] <= fp_mul(p1_val_reg[i], vec_rd[i]);
            end
        end
    end

    assign fin_now = p2_vld_reg && p2_req_reg == REQ_FIN;
    assign blk_now = p2_vld_reg && p2_req_reg == REQ_BLK;

    // Lane adders; on a row finish lanes 0 and 1 form the pair sums instead
    always_comb begin
        add_out[0] = fin_now ? fp_add(acc_reg[2], acc_reg[0])
                             : fp_add(acc_reg[0], p2_prod_reg[0]);
        add_out[1] = fin_now ? fp_add(acc_reg[3], acc_reg[1])
                             : fp_add(acc_reg[1], p2_prod_reg[1]);
        add_out[2] = fp_add(acc_reg[2], p2_prod_reg[2]);
        add_out[3] = fp_add(acc_reg[3], p2_prod_reg[3]);
        for (int i = 0; i < LANES; i++) begin
            if (fin_now)      acc_next[i] = 32'd0;
            else if (blk_now) acc_next[i] = add_out[i];
            else              acc_next[i] = acc_reg[i];
        end
        row_next = row_reg;
        if (fin_now) begin
            row_next = (row_reg == ROW_W'(MAX_ROWS - 1)) ? '0 : row_reg + 1'b1;
        end
        fin.vld     = fin_now;
        fin.row     = row_reg;
        fin.c_prior = p2_c_reg;
        fin.r0      = add_out[0];
        fin.r1      = add_out[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            for (int i = 0; i < LANES; i++) acc_reg[i] <= 32'd0;
        end else if (adv) begin
            row_reg <= row_next;
            for (int i = 0; i < LANES; i++) acc_reg[i] <= acc_next[i];
        end
    end

    bcsr_reduce u_reduce (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fin          (fin),
        .adv          (adv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_number (m_row_number),
        .m_row_result (m_row_result)
    );

    a_lanes_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_now && adv) |=> (acc_reg[0] == 32'd0 && acc_reg[1] == 32'd0
                              && acc_reg[2] == 32'd0 && acc_reg[3] == 32'd0))
        else $error("lane sums not cleared after row finish");

    a_ready_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input blocked while output is free");

    a_row_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!fin_now || !adv) |=> row_reg == $past(row_reg))
        else $error("row count moved without a row finish");

endmodule

/* tb/bcsr_row_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcsr_row_checker
// Watches both channels of the block sparse accumulator, keeps its own copy
// of the dense vector, lane sums and row count, predicts each finished row
// bit for bit in IEEE single precision and compares it on arrival.
// ----------------------------------------------------------------------------
module bcsr_row_checker import bcsr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [11:0]      s_vec_index,
    input  logic [31:0]      s_vec_value,
    input  logic [9:0]       s_block_col,
    input  logic [31:0]      s_val0,
    input  logic [31:0]      s_val1,
    input  logic [31:0]      s_val2,
    input  logic [31:0]      s_val3,
    input  logic [31:0]      s_c_prior,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [ROW_W-1:0] m_row_number,
    input  logic [31:0]      m_row_result,
    output int               fail_count,
    output int               rows_pending
);

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [31:0]      sum;
    } row_sum_t;

    row_sum_t         expected_rows[$];
    logic [31:0]      vec_copy[VEC_DEPTH];
    logic [31:0]      lane_acc[LANES];
    logic [ROW_W-1:0] row_ctr;

    function automatic bit is_nan(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic longint unsigned sig_of(logic [31:0] x);
        return (x[30:23] == 8'd0) ? longint'(x[22:0]) : longint'({1'b1, x[22:0]});
    endfunction

    // weight of the significand lsb as a power of two
    function automatic int scale_of(logic [31:0] x);
        return (x[30:23] == 8'd0) ? -149 : int'(x[30:23]) - 150;
    endfunction

    // Round mant * 2^pw to nearest even single; mant is nonzero.
    function automatic logic [31:0] round_pack(logic sgn, longint unsigned mant, int pw);
        int              msb;
        int              sh;
        int              w;
        longint unsigned m;
        bit              g;
        bit              st;
        msb = 0;
        for (int i = 0; i < 64; i++) if (mant[i]) msb = i;
        sh = msb - 23;
        if (-149 - pw > sh) sh = -149 - pw;
        if (sh <= 0) begin
            m = mant << (-sh);
        end else begin
            m  = (sh >= 64) ? 64'd0 : (mant >> sh);
            g  = (sh <= 64) ? mant[sh-1] : 1'b0;
            st = (sh >= 65) ? 1'b1
                            : ((mant & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0);
            if (g && (st || m[0])) m = m + 64'd1;
        end
        w = pw + sh;
        if (m == 64'd1 << 24) begin
            m = 64'd1 << 23;
            w = w + 1;
        end
        if (m >= 64'd1 << 23) begin
            if (w + 150 >= 255) return {sgn, 8'hFF, 23'd0};
            return {sgn, 8'(w + 150), m[22:0]};
        end
        return {sgn, 8'd0, m[22:0]};
    endfunction

    function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
        logic sgn;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN;
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0)) return QNAN;
        if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'd0};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
        return round_pack(sgn, sig_of(a) * sig_of(b), scale_of(a) + scale_of(b));
    endfunction

    function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0]     t;
        longint unsigned big;
        longint unsigned lil;
        int              d;
        int              pw;
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 31'd0) return b;
        if (b[30:0] == 31'd0) return a;
        if (a[30:0] < b[30:0]) begin
            t = a; a = b; b = t;
        end
        d = scale_of(a) - scale_of(b);
        if (d <= 38) begin
            big = sig_of(a) << d;
            lil = sig_of(b);
            pw  = scale_of(b);
        end else begin
            // the small operand only matters as a sticky bit far below rounding
            big = sig_of(a) << 40;
            lil = 64'd1;
            pw  = scale_of(a) - 40;
        end
        if (a[31] == b[31]) return round_pack(a[31], big + lil, pw);
        if (big == lil) return 32'd0;
        return round_pack(a[31], big - lil, pw);
    endfunction

    always @(posedge aclk) begin
        logic [31:0] vals[LANES];
        logic [31:0] half_a;
        logic [31:0] half_b;
        logic [31:0] total;
        row_sum_t    got;
        row_sum_t    want;
        if (!aresetn) begin
            for (int l = 0; l < LANES; l++) lane_acc[l] = 32'd0;
            row_ctr = '0;
            expected_rows.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.row = m_row_number;
                got.sum = m_row_result;
                if (expected_rows.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("%0t: unexpected row %0d result %h", $realtime,
                                 got.row, got.sum);
                end else begin
                    want = expected_rows.pop_front();
                    if (got.row !== want.row || got.sum !== want.sum) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("%0t: row mismatch exp row %0d sum %h, got row %0d sum %h",
                                     $realtime, want.row, want.sum, got.row, got.sum);
                    end
                end
            end
            if (s_valid && s_ready) begin
                vals[0] = s_val0; vals[1] = s_val1; vals[2] = s_val2; vals[3] = s_val3;
                case (s_req_type)
                    REQ_VEC: begin
                        vec_copy[s_vec_index] = s_vec_value;
                    end
                    REQ_BLK: begin
                        for (int l = 0; l < LANES; l++)
                            lane_acc[l] = fp32_add(lane_acc[l],
                                fp32_mul(vals[l], vec_copy[{s_block_col, 2'(l)}]));
                    end
                    REQ_FIN: begin
                        half_a = fp32_add(lane_acc[2], lane_acc[0]);
                        half_b = fp32_add(lane_acc[3], lane_acc[1]);
                        total  = fp32_add(s_c_prior, fp32_add(half_a, half_b));
                        if (is_nan(total)) total = QNAN;
                        want.row = row_ctr;
                        want.sum = total;
                        expected_rows.push_back(want);
                        for (int l = 0; l < LANES; l++) lane_acc[l] = 32'd0;
                        row_ctr = row_ctr + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        rows_pending = expected_rows.size();
    end

endmodule

/* tb/block_csr_spmv_accumulator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_csr_spmv_accumulator_tb
// Drives vector writes, matrix blocks and row finishes into the accumulator
// with bursty input and a stalling output, lets the checker predict and
// compare every finished row, and reports the verdict.
// ----------------------------------------------------------------------------
module block_csr_spmv_accumulator_tb;
    import bcsr_pkg::*;

    // request code the block has no use for; it must be dropped silently
    localparam logic [1:0] REQ_IDLE_CODE = 2'd3;
    localparam int RANDOM_TXNS = 1550;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 20;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_req_type;
    logic [11:0]      s_vec_index;
    logic [31:0]      s_vec_value;
    logic [9:0]       s_block_col;
    logic [31:0]      s_val0;
    logic [31:0]      s_val1;
    logic [31:0]      s_val2;
    logic [31:0]      s_val3;
    logic [31:0]      s_c_prior;
    logic             m_valid;
    logic             m_ready;
    logic [ROW_W-1:0] m_row_number;
    logic [31:0]      m_row_result;

    int fail_count;
    int rows_pending;
    int cycle_ctr = 0;
    int sent_txns;
    int burst_left;

    // which vector entries hold data, and which block columns are fully loaded
    bit vec_loaded[VEC_DEPTH];
    int ready_cols[$];

    block_csr_spmv_accumulator u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_vec_index  (s_vec_index),
        .s_vec_value  (s_vec_value),
        .s_block_col  (s_block_col),
        .s_val0       (s_val0),
        .s_val1       (s_val1),
        .s_val2       (s_val2),
        .s_val3       (s_val3),
        .s_c_prior    (s_c_prior),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_number (m_row_number),
        .m_row_result (m_row_result)
    );

    bcsr_row_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_vec_index  (s_vec_index),
        .s_vec_value  (s_vec_value),
        .s_block_col  (s_block_col),
        .s_val0       (s_val0),
        .s_val1       (s_val1),
        .s_val2       (s_val2),
        .s_val3       (s_val3),
        .s_c_prior    (s_c_prior),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_number (m_row_number),
        .m_row_result (m_row_result),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (cycle_ctr >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Pick a float bit pattern: specials, subnormals, tame magnitudes that
    // keep sums meaningful, or plain random bits.
    function automatic logic [31:0] pick_float();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 15))
            0: return {r[31], 31'd0};                          // signed zero
            1: return {r[31], 8'hFF, 23'd0};                   // infinity
            2: return {r[31], 8'hFF, r[22:1], 1'b1};           // NaN
            3: return {r[31], 8'd0, r[22:0]};                  // subnormal
            4: return {r[31], 8'hFE, r[22:0]};                 // near overflow
            5: return {r[31], 8'd1, r[22:0]};                  // smallest normals
            6, 7: return r;
            default: return {r[31], 8'(8'd120 + r[26:23]), r[22:0]};
        endcase
    endfunction

    // Offer one transaction and hold it until the block takes it; bursts of
    // random length are separated by random gaps.
    task automatic send_txn(logic [1:0] kind, logic [11:0] idx, logic [31:0] vv,
                            logic [9:0] col, logic [31:0] v0, logic [31:0] v1,
                            logic [31:0] v2, logic [31:0] v3, logic [31:0] cp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_vec_index <= idx;
        s_vec_value <= vv;
        s_block_col <= col;
        s_val0      <= v0;
        s_val1      <= v1;
        s_val2      <= v2;
        s_val3      <= v3;
        s_c_prior   <= cp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_txns = sent_txns + 1;
        if (kind == REQ_VEC && !vec_loaded[idx]) begin
            vec_loaded[idx] = 1'b1;
            if (vec_loaded[{idx[11:2], 2'd0}] && vec_loaded[{idx[11:2], 2'd1}] &&
                vec_loaded[{idx[11:2], 2'd2}] && vec_loaded[{idx[11:2], 2'd3}])
                ready_cols.push_back(int'(idx[11:2]));
        end
    endtask

    task automatic write_vec(logic [11:0] idx, logic [31:0] vv);
        send_txn(REQ_VEC, idx, vv, 10'($urandom), $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    endtask

    task automatic load_column(logic [9:0] col);
        for (int l = 0; l < LANES; l++) write_vec({col, 2'(l)}, pick_float());
    endtask

    task automatic send_block(logic [9:0] col, logic [31:0] v0, logic [31:0] v1,
                              logic [31:0] v2, logic [31:0] v3);
        send_txn(REQ_BLK, 12'($urandom), $urandom, col, v0, v1, v2, v3, $urandom);
    endtask

    task automatic finish_row(logic [31:0] cp);
        send_txn(REQ_FIN, 12'($urandom), $urandom, 10'($urandom), $urandom, $urandom,
                 $urandom, $urandom, cp);
    endtask

    // Receiver: switch between random stall patterns, and once hold off for a
    // long stretch so the pipeline backs up into the input.
    initial begin
        int mode;
        int long_hold;
        m_ready = 1'b0;
        long_hold = 0;
        mode = 0;
        forever begin
            @(posedge aclk);
            if (cycle_ctr % 64 == 0) mode = $urandom_range(0, 3);
            if (long_hold == 0 && sent_txns >= 300) long_hold = 1;
            if (long_hold >= 1 && long_hold <= 300) begin
                long_hold = long_hold + 1;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 0);
                    2: m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        int choice;
        int col;
        sent_txns   = 0;
        burst_left  = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_req_type  = REQ_VEC;
        s_vec_index = '0;
        s_vec_value = '0;
        s_block_col = '0;
        s_val0      = '0;
        s_val1      = '0;
        s_val2      = '0;
        s_val3      = '0;
        s_c_prior   = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme columns, signed zeros, infinities, NaN, overflow,
        // the unused request code and a finish on empty lanes.
        write_vec(12'd0, 32'h3F80_0000);
        write_vec(12'd1, 32'h8000_0000);
        write_vec(12'd2, 32'h7F80_0000);
        write_vec(12'd3, 32'h0000_0001);
        write_vec(12'd4092, 32'h7F7F_FFFF);
        write_vec(12'd4093, 32'hFFFF_FFFF);
        write_vec(12'd4094, 32'h0080_0000);
        write_vec(12'd4095, 32'hC000_0000);
        send_block(10'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h3F80_0000, 32'h4B00_0000);
        send_block(10'd1023, 32'h7F7F_FFFF, 32'h0000_0000, 32'h3F00_0000, 32'h0000_0000);
        finish_row(32'h0000_0000);
        send_block(10'd0, 32'h3F80_0000, 32'h7F80_0000, 32'h0000_0000, 32'h4000_0000);
        finish_row(32'hFF80_0000);
        send_txn(REQ_IDLE_CODE, 12'hFFF, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        finish_row(32'h8000_0000);
        send_block(10'd1023, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        finish_row(32'h7FC0_0001);
        send_block(10'd0, 32'h0000_0001, 32'h3F80_0000, 32'h8000_0001, 32'h0000_0000);
        finish_row(32'h8000_0000);

        // Random: mostly loaded columns feeding blocks, with row finishes,
        // fresh vector loads and the occasional unused code.
        for (int n = 0; n < RANDOM_TXNS; n++) begin
            choice = $urandom_range(0, 99);
            if (choice < 6) begin
                load_column(10'($urandom));
            end else if (choice < 12) begin
                write_vec(12'($urandom), pick_float());
            end else if (choice < 72) begin
                col = ready_cols[$urandom_range(0, ready_cols.size() - 1)];
                send_block(10'(col), pick_float(), pick_float(), pick_float(), pick_float());
            end else if (choice < 96) begin
                finish_row(($urandom_range(0, 2) == 0) ? pick_float() : 32'd0);
            end else begin
                send_txn(REQ_IDLE_CODE, 12'($urandom), $urandom, 10'($urandom), $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end
        end
        s_valid <= 1'b0;

        // Drain: let the checker take the last transaction, wait for every
        // row, then give the pipeline time to misbehave.
        @(posedge aclk);
        while (rows_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
